FILE: hdl/geu_pkg.sv
// ----------------------------------------------------------------------------
// geu_pkg: guided euler latent update, shared definitions
// widths, register map, reset values and the item structs that pass
// between the pipeline sections
// ----------------------------------------------------------------------------
`default_nettype none

package geu_pkg;

   // latent fixed-point format: signed Q(31-F).F
   localparam int LATENT_FRAC_BITS = 16;

   localparam int CODE_W      = 16;
   localparam int LAT_W       = 32;
   localparam int GUIDE_W     = 16;
   localparam int GUIDE_FRAC  = 8;
   localparam int SIGMA_W     = 24;
   localparam int SCALE_W     = 32;
   localparam int INV_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // code minus zero point, and difference of two of those
   localparam int DIFF1_W = CODE_W + 1;
   localparam int DIFF2_W = CODE_W + 2;

   // guided mix, Q.8 signed, and its magnitude split for the scale multiply
   localparam int MIX_W    = GUIDE_W + DIFF2_W + 1;
   localparam int MIXMAG_W = MIX_W - 1;
   localparam int MIXLO_W  = MIXMAG_W / 2;
   localparam int MIXHI_W  = MIXMAG_W - MIXLO_W;

   // dequantized noise magnitude, Q.32
   localparam int NOISE_SH   = GUIDE_FRAC;
   localparam int NOISE_W    = MIXMAG_W + SCALE_W - NOISE_SH;
   localparam int NOISELO_W  = NOISE_W / 2;
   localparam int NOISEHI_W  = NOISE_W - NOISELO_W;

   // sigma products, back in the latent format
   localparam int STEP_SH = 48 - LATENT_FRAC_BITS;
   localparam int STEP_W  = NOISE_W + SIGMA_W - STEP_SH;

   // preview latent, signed, and its magnitude split for the inverse scale
   localparam int X0_W    = STEP_W + 2;
   localparam int X0MAG_W = STEP_W + 1;
   localparam int X0LO_W  = (X0MAG_W + 1) / 2;
   localparam int X0HI_W  = X0MAG_W - X0LO_W;

   // requantization: magnitudes at or above 2^PREV_CAP_W always clamp
   localparam int PREV_SH    = LATENT_FRAC_BITS + 16;
   localparam int PREV_CAP_W = CODE_W + 2;
   localparam int CAPPED_W   = PREV_CAP_W + 1;
   localparam logic [INV_W-1:0] INV_ONE = INV_W'(65536);

   // register stages from an accepted item to its result strobe
   localparam int PIPE_DEPTH = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GUIDANCE_SCALE    = 3'd0,
      CSR_SIGMA_NOW         = 3'd1,
      CSR_SIGMA_AFTER       = 3'd2,
      CSR_NOISE_SCALE       = 3'd3,
      CSR_NOISE_OFFSET      = 3'd4,
      CSR_PREVIEW_INV_SCALE = 3'd5,
      CSR_PREVIEW_OFFSET    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GUIDE_W-1:0] guidance_scale;
      logic [SIGMA_W-1:0] sigma_now;
      logic [SIGMA_W-1:0] sigma_after;
      logic [SCALE_W-1:0] noise_scale;
      logic [CODE_W-1:0]  noise_offset;
      logic [INV_W-1:0]   preview_inv_scale;
      logic [CODE_W-1:0]  preview_offset;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      guidance_scale:    16'd1920,
      sigma_now:         24'd0,
      sigma_after:       24'd0,
      noise_scale:       32'd808199,
      noise_offset:      16'd32340,
      preview_inv_scale: 32'd192731939,
      preview_offset:    16'd34382
   };

   // noise section to step section
   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic [NOISE_W-1:0]        mag;
      logic signed [LAT_W-1:0]   latent;
   } noise_item_type;

   // step section to preview section
   typedef struct packed {
      logic                      valid;
      logic signed [X0_W-1:0]    x0;
      logic signed [LAT_W-1:0]   latent_out;
      logic                      saturated;
   } step_item_type;

endpackage

`default_nettype wire

FILE: hdl/geu_csr.sv
// ----------------------------------------------------------------------------
// geu_csr: configuration registers
// write-only register file, out-of-range indexes are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module geu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [geu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [geu_pkg::CSR_DATA_W-1:0]      csr_data,
   output geu_pkg::csr_type                    cfg
);

   geu_pkg::csr_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            geu_pkg::CSR_GUIDANCE_SCALE:
               cfg_in.guidance_scale = csr_data[geu_pkg::GUIDE_W-1:0];
            geu_pkg::CSR_SIGMA_NOW:
               cfg_in.sigma_now = csr_data[geu_pkg::SIGMA_W-1:0];
            geu_pkg::CSR_SIGMA_AFTER:
               cfg_in.sigma_after = csr_data[geu_pkg::SIGMA_W-1:0];
            geu_pkg::CSR_NOISE_SCALE:
               cfg_in.noise_scale = csr_data[geu_pkg::SCALE_W-1:0];
            geu_pkg::CSR_NOISE_OFFSET:
               cfg_in.noise_offset = csr_data[geu_pkg::CODE_W-1:0];
            geu_pkg::CSR_PREVIEW_INV_SCALE:
               cfg_in.preview_inv_scale = csr_data[geu_pkg::INV_W-1:0];
            geu_pkg::CSR_PREVIEW_OFFSET:
               cfg_in.preview_offset = csr_data[geu_pkg::CODE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= geu_pkg::CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/geu_noise.sv
// ----------------------------------------------------------------------------
// geu_noise: guidance mix and noise dequantization
// five stages: zero point, guided mix, magnitude, split scale multiply,
// rounding shift
// ----------------------------------------------------------------------------
`default_nettype none

module geu_noise (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [geu_pkg::CODE_W-1:0]          cond_code,
   input  logic [geu_pkg::CODE_W-1:0]          uncond_code,
   input  logic signed [geu_pkg::LAT_W-1:0]    latent_in,
   input  geu_pkg::csr_type                    cfg,
   output geu_pkg::noise_item_type             noise_out
);

   localparam int D1W = geu_pkg::DIFF1_W;
   localparam int D2W = geu_pkg::DIFF2_W;
   localparam int MW  = geu_pkg::MIX_W;
   localparam int MMW = geu_pkg::MIXMAG_W;
   localparam int MLW = geu_pkg::MIXLO_W;
   localparam int MHW = geu_pkg::MIXHI_W;
   localparam int SW  = geu_pkg::SCALE_W;
   localparam int LW  = geu_pkg::LAT_W;
   localparam int PW  = MMW + SW;
   localparam logic [PW-1:0] ROUND_BIAS = PW'(1) << (geu_pkg::NOISE_SH - 1);

   // stage a: codes minus zero point
   logic signed [D1W-1:0] a_dc_in, a_du_in;
   logic signed [D2W-1:0] a_diff_in;
   logic                  a_valid_ff;
   logic signed [D1W-1:0] a_du_ff;
   logic signed [D2W-1:0] a_diff_ff;
   logic signed [LW-1:0]  a_lat_ff;

   // stage b: uncond*256 + g*(cond - uncond)
   logic signed [MW-1:0]  b_prod_in, b_mix_in;
   logic                  b_valid_ff;
   logic signed [MW-1:0]  b_mix_ff;
   logic signed [LW-1:0]  b_lat_ff;

   // stage c: sign and magnitude
   logic [MMW-1:0]        c_mag_in;
   logic                  c_valid_ff, c_neg_ff;
   logic [MMW-1:0]        c_mag_ff;
   logic signed [LW-1:0]  c_lat_ff;

   // stage d: two partial products with the noise scale
   logic                  d_valid_ff, d_neg_ff;
   logic [MLW+SW-1:0]     d_plo_ff;
   logic [MHW+SW-1:0]     d_phi_ff;
   logic signed [LW-1:0]  d_lat_ff;

   // stage e: recombine, round and drop the guidance fraction
   logic [PW-1:0]         e_sum_in;
   logic                  e_valid_ff, e_neg_ff;
   logic [geu_pkg::NOISE_W-1:0] e_mag_ff;
   logic signed [LW-1:0]  e_lat_ff;

   assign a_dc_in   = $signed({1'b0, cond_code}) - $signed({1'b0, cfg.noise_offset});
   assign a_du_in   = $signed({1'b0, uncond_code}) - $signed({1'b0, cfg.noise_offset});
   assign a_diff_in = D2W'(a_dc_in) - D2W'(a_du_in);

   assign b_prod_in = $signed({1'b0, cfg.guidance_scale}) * a_diff_ff;
   assign b_mix_in  = (MW'(a_du_ff) <<< geu_pkg::GUIDE_FRAC) + b_prod_in;

   assign c_mag_in  = b_mix_ff[MW-1] ? MMW'(-b_mix_ff) : MMW'(b_mix_ff);

   assign e_sum_in  = PW'(d_plo_ff) + (PW'(d_phi_ff) << MLW) + ROUND_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_du_ff   <= a_du_in;
      a_diff_ff <= a_diff_in;
      a_lat_ff  <= latent_in;

      b_mix_ff  <= b_mix_in;
      b_lat_ff  <= a_lat_ff;

      c_neg_ff  <= b_mix_ff[MW-1];
      c_mag_ff  <= c_mag_in;
      c_lat_ff  <= b_lat_ff;

      d_neg_ff  <= c_neg_ff;
      d_plo_ff  <= c_mag_ff[MLW-1:0] * cfg.noise_scale;
      d_phi_ff  <= c_mag_ff[MMW-1:MLW] * cfg.noise_scale;
      d_lat_ff  <= c_lat_ff;

      e_neg_ff  <= d_neg_ff;
      e_mag_ff  <= e_sum_in[PW-1:geu_pkg::NOISE_SH];
      e_lat_ff  <= d_lat_ff;
   end

   assign noise_out.valid  = e_valid_ff;
   assign noise_out.neg    = e_neg_ff;
   assign noise_out.mag    = e_mag_ff;
   assign noise_out.latent = e_lat_ff;

endmodule

`default_nettype wire

FILE: hdl/geu_step.sv
// ----------------------------------------------------------------------------
// geu_step: sigma products, preview latent and euler update
// three stages: split multiplies, rounding shift, add and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module geu_step (
   input  logic                                clock,
   input  logic                                reset,
   input  geu_pkg::noise_item_type             noise_in,
   input  geu_pkg::csr_type                    cfg,
   output geu_pkg::step_item_type              step_out
);

   localparam int NW  = geu_pkg::NOISE_W;
   localparam int NLW = geu_pkg::NOISELO_W;
   localparam int NHW = geu_pkg::NOISEHI_W;
   localparam int GW  = geu_pkg::SIGMA_W;
   localparam int SW  = geu_pkg::STEP_W;
   localparam int XW  = geu_pkg::X0_W;
   localparam int LW  = geu_pkg::LAT_W;
   localparam int PW  = NW + GW;
   localparam logic [PW-1:0] ROUND_BIAS = PW'(1) << (geu_pkg::STEP_SH - 1);
   localparam logic signed [LW-1:0] LAT_MAX = {1'b0, {(LW-1){1'b1}}};
   localparam logic signed [LW-1:0] LAT_MIN = {1'b1, {(LW-1){1'b0}}};

   // sigma_after - sigma_now, held as sign and magnitude
   logic signed [GW:0]    delta_in;
   logic                  dneg_ff;
   logic [GW-1:0]         dmag_ff;

   // stage f
   logic                  f_valid_ff, f_sneg_ff, f_uneg_ff;
   logic [NLW+GW-1:0]     f_slo_ff, f_ulo_ff;
   logic [NHW+GW-1:0]     f_shi_ff, f_uhi_ff;
   logic signed [LW-1:0]  f_lat_ff;

   // stage g
   logic [PW-1:0]         g_ssum_in, g_usum_in;
   logic                  g_valid_ff, g_sneg_ff, g_uneg_ff;
   logic [SW-1:0]         g_smag_ff, g_umag_ff;
   logic signed [LW-1:0]  g_lat_ff;

   // stage h
   logic signed [XW-1:0]  h_lat_in, h_s_in, h_u_in, h_x0_in, h_sum_in;
   logic                  h_fits_in;
   logic                  h_valid_ff, h_sat_ff;
   logic signed [XW-1:0]  h_x0_ff;
   logic signed [LW-1:0]  h_lat_ff;

   assign delta_in = $signed({1'b0, cfg.sigma_after}) - $signed({1'b0, cfg.sigma_now});

   assign g_ssum_in = PW'(f_slo_ff) + (PW'(f_shi_ff) << NLW) + ROUND_BIAS;
   assign g_usum_in = PW'(f_ulo_ff) + (PW'(f_uhi_ff) << NLW) + ROUND_BIAS;

   assign h_lat_in  = XW'(g_lat_ff);
   assign h_s_in    = g_sneg_ff ? -$signed(XW'(g_smag_ff)) : $signed(XW'(g_smag_ff));
   assign h_u_in    = g_uneg_ff ? -$signed(XW'(g_umag_ff)) : $signed(XW'(g_umag_ff));
   assign h_x0_in   = h_lat_in - h_s_in;
   assign h_sum_in  = h_lat_in + h_u_in;
   // in range when all bits above the latent msb repeat the sign
   assign h_fits_in = (&h_sum_in[XW-1:LW-1]) | ~(|h_sum_in[XW-1:LW-1]);

   always_ff @(posedge clock) begin
      dneg_ff <= delta_in[GW];
      dmag_ff <= delta_in[GW] ? GW'(-delta_in) : GW'(delta_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= noise_in.valid;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_sneg_ff <= noise_in.neg;
      f_uneg_ff <= noise_in.neg ^ dneg_ff;
      f_slo_ff  <= noise_in.mag[NLW-1:0] * cfg.sigma_now;
      f_shi_ff  <= noise_in.mag[NW-1:NLW] * cfg.sigma_now;
      f_ulo_ff  <= noise_in.mag[NLW-1:0] * dmag_ff;
      f_uhi_ff  <= noise_in.mag[NW-1:NLW] * dmag_ff;
      f_lat_ff  <= noise_in.latent;

      g_sneg_ff <= f_sneg_ff;
      g_uneg_ff <= f_uneg_ff;
      g_smag_ff <= g_ssum_in[PW-1:geu_pkg::STEP_SH];
      g_umag_ff <= g_usum_in[PW-1:geu_pkg::STEP_SH];
      g_lat_ff  <= f_lat_ff;

      h_x0_ff   <= h_x0_in;
      h_sat_ff  <= ~h_fits_in;
      if (h_fits_in) begin
         h_lat_ff <= h_sum_in[LW-1:0];
      end else if (h_sum_in[XW-1]) begin
         h_lat_ff <= LAT_MIN;
      end else begin
         h_lat_ff <= LAT_MAX;
      end
   end

   assign step_out.valid      = h_valid_ff;
   assign step_out.x0         = h_x0_ff;
   assign step_out.latent_out = h_lat_ff;
   assign step_out.saturated  = h_sat_ff;

   // a zero update step can never push the latent out of range
   a_no_sat_without_step: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff && g_umag_ff == '0 |=> !h_sat_ff)
      else $error("latent saturated with zero update");

   // a clamped latent sits at one of the two range limits
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff && h_sat_ff |-> (h_lat_ff == LAT_MAX || h_lat_ff == LAT_MIN))
      else $error("saturated latent not at a range limit");

endmodule

`default_nettype wire

FILE: hdl/geu_preview.sv
// ----------------------------------------------------------------------------
// geu_preview: requantization of the preview latent
// four stages: magnitude, split inverse-scale multiply, rounding shift with
// cap, zero point and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module geu_preview (
   input  logic                                clock,
   input  logic                                reset,
   input  geu_pkg::step_item_type              step_in,
   input  geu_pkg::csr_type                    cfg,
   output logic                                rsp_valid,
   output logic [geu_pkg::CODE_W-1:0]          rsp_preview_code,
   output logic signed [geu_pkg::LAT_W-1:0]    rsp_latent_out,
   output logic                                rsp_saturated
);

   localparam int XW  = geu_pkg::X0_W;
   localparam int XMW = geu_pkg::X0MAG_W;
   localparam int XLW = geu_pkg::X0LO_W;
   localparam int XHW = geu_pkg::X0HI_W;
   localparam int IW  = geu_pkg::INV_W;
   localparam int CW  = geu_pkg::CODE_W;
   localparam int RW  = geu_pkg::CAPPED_W;
   localparam int LW  = geu_pkg::LAT_W;
   localparam int PW  = XMW + IW;
   localparam int QW  = PW - geu_pkg::PREV_SH;
   localparam int VW  = RW + 2;
   localparam logic [PW-1:0] ROUND_BIAS = PW'(1) << (geu_pkg::PREV_SH - 1);
   localparam logic [QW-1:0] Q_CAP = QW'(1) << geu_pkg::PREV_CAP_W;
   localparam logic [RW-1:0] R_CAP = RW'(1) << geu_pkg::PREV_CAP_W;

   // zero reciprocal scale reads as one
   logic [IW-1:0]         inv_ff;

   // stage i
   logic                  i_valid_ff, i_neg_ff, i_sat_ff;
   logic [XMW-1:0]        i_mag_ff;
   logic signed [LW-1:0]  i_lat_ff;

   // stage j
   logic                  j_valid_ff, j_neg_ff, j_sat_ff;
   logic [XLW+IW-1:0]     j_plo_ff;
   logic [XHW+IW-1:0]     j_phi_ff;
   logic signed [LW-1:0]  j_lat_ff;

   // stage k
   logic [PW-1:0]         k_sum_in;
   logic [QW-1:0]         k_q_in;
   logic                  k_valid_ff, k_neg_ff, k_sat_ff;
   logic [RW-1:0]         k_r_ff;
   logic signed [LW-1:0]  k_lat_ff;

   // stage l
   logic signed [VW-1:0]  l_v_in;
   logic                  l_valid_ff, l_sat_ff;
   logic [CW-1:0]         l_code_ff;
   logic signed [LW-1:0]  l_lat_ff;

   assign k_sum_in = PW'(j_plo_ff) + (PW'(j_phi_ff) << XLW) + ROUND_BIAS;
   assign k_q_in   = k_sum_in[PW-1:geu_pkg::PREV_SH];

   assign l_v_in = k_neg_ff ? $signed(VW'(cfg.preview_offset) - VW'(k_r_ff))
                            : $signed(VW'(cfg.preview_offset) + VW'(k_r_ff));

   always_ff @(posedge clock) begin
      inv_ff <= (cfg.preview_inv_scale == '0) ? geu_pkg::INV_ONE : cfg.preview_inv_scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
      end else begin
         i_valid_ff <= step_in.valid;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
         l_valid_ff <= k_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_neg_ff <= step_in.x0[XW-1];
      i_mag_ff <= step_in.x0[XW-1] ? XMW'(-step_in.x0) : XMW'(step_in.x0);
      i_sat_ff <= step_in.saturated;
      i_lat_ff <= step_in.latent_out;

      j_neg_ff <= i_neg_ff;
      j_plo_ff <= i_mag_ff[XLW-1:0] * inv_ff;
      j_phi_ff <= i_mag_ff[XMW-1:XLW] * inv_ff;
      j_sat_ff <= i_sat_ff;
      j_lat_ff <= i_lat_ff;

      k_neg_ff <= j_neg_ff;
      k_r_ff   <= (k_q_in >= Q_CAP) ? R_CAP : k_q_in[RW-1:0];
      k_sat_ff <= j_sat_ff;
      k_lat_ff <= j_lat_ff;

      if (l_v_in[VW-1]) begin
         l_code_ff <= '0;
      end else if (|l_v_in[VW-2:CW]) begin
         l_code_ff <= '1;
      end else begin
         l_code_ff <= l_v_in[CW-1:0];
      end
      l_sat_ff <= k_sat_ff;
      l_lat_ff <= k_lat_ff;
   end

   assign rsp_valid        = l_valid_ff;
   assign rsp_preview_code = l_code_ff;
   assign rsp_latent_out   = l_lat_ff;
   assign rsp_saturated    = l_sat_ff;

   // a capped positive quotient always clamps to the top code
   a_cap_high: assert property (@(posedge clock) disable iff (reset)
      k_valid_ff && k_r_ff == R_CAP && !k_neg_ff |=> rsp_preview_code == '1)
      else $error("capped positive preview not clamped high");

   // a capped negative quotient always clamps to zero
   a_cap_low: assert property (@(posedge clock) disable iff (reset)
      k_valid_ff && k_r_ff == R_CAP && k_neg_ff |=> rsp_preview_code == '0)
      else $error("capped negative preview not clamped low");

endmodule

`default_nettype wire

FILE: hdl/guided_euler_latent_update_unit.sv
// ----------------------------------------------------------------------------
// guided_euler_latent_update_unit: guided euler step on one latent element
// classifier-free guidance of two noise codes, preview requantization and
// saturating euler update, fully pipelined
// ----------------------------------------------------------------------------
// Usage: raise start with an item on req_*; it is taken at any clock edge
// where busy is low, which is every cycle outside reset, so a new item can
// enter on every clock. Each item comes back as a one-cycle rsp_valid
// strobe with rsp_* beside it, in the order the items went in. The
// receiver cannot stall: the pipeline never holds and results must be
// captured on the strobe. The pipeline has five stages for the guided mix
// and noise dequantization, three for the sigma products and the latent
// update, four for requantizing the preview latent; the wide products are
// split into narrow partial products one stage ahead of their rounding
// shift. Registers are written through csr_* (csr_ready is always high)
// and must only change while no item is in flight. A reciprocal preview
// scale of zero acts as 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module guided_euler_latent_update_unit (
   input  logic                                clock,
   input  logic                                reset,

   // item in
   input  logic                                start,
   output logic                                busy,
   input  logic [geu_pkg::CODE_W-1:0]          req_cond_code,
   input  logic [geu_pkg::CODE_W-1:0]          req_uncond_code,
   input  logic signed [geu_pkg::LAT_W-1:0]    req_latent_in,

   // item out
   output logic                                rsp_valid,
   output logic [geu_pkg::CODE_W-1:0]          rsp_preview_code,
   output logic signed [geu_pkg::LAT_W-1:0]    rsp_latent_out,
   output logic                                rsp_saturated,

   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [geu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [geu_pkg::CSR_DATA_W-1:0]      csr_data
);

   geu_pkg::csr_type        cfg;
   geu_pkg::noise_item_type noise_item;
   geu_pkg::step_item_type  step_item;
   logic                    accept;

   // only reset holds items off, the pipeline itself never backs up
   assign busy   = reset;
   assign accept = start & ~busy;

   // configuration register file
   geu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // zero points, guided mix, noise dequantization
   geu_noise u_noise (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cond_code   (req_cond_code),
      .uncond_code (req_uncond_code),
      .latent_in   (req_latent_in),
      .cfg         (cfg),
      .noise_out   (noise_item)
   );

   // sigma * noise, preview latent, saturating update
   geu_step u_step (
      .clock    (clock),
      .reset    (reset),
      .noise_in (noise_item),
      .cfg      (cfg),
      .step_out (step_item)
   );

   // requantize the preview latent, carry the update alongside
   geu_preview u_preview (
      .clock            (clock),
      .reset            (reset),
      .step_in          (step_item),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_preview_code (rsp_preview_code),
      .rsp_latent_out   (rsp_latent_out),
      .rsp_saturated    (rsp_saturated)
   );

   // every accepted item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(geu_pkg::PIPE_DEPTH) rsp_valid)
      else $error("accepted item did not come out on time");

   // and no result shows up without an item behind it
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##(geu_pkg::PIPE_DEPTH) !rsp_valid)
      else $error("result strobe without an accepted item");

endmodule

`default_nettype wire

FILE: bench/guided_euler_latent_update_unit_tb.sv
// ----------------------------------------------------------------------------
// guided_euler_latent_update_unit_tb: self-checking bench for the latent update
// drives noise code pairs and latent elements through the start/busy port,
// predicts each preview code and updated latent with a fixed-point model of
// the guided euler step, and checks every strobed result in order; register
// settings change between phases, only while the pipeline is empty
// ----------------------------------------------------------------------------
module guided_euler_latent_update_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import geu_pkg::*;

   localparam int      CLK_HALF     = 4;
   localparam int      RESET_CYCLES = 6;
   localparam int      RANDOM_ITEMS = 1250;
   localparam int      REPORT_LIMIT = 10;
   localparam int      DRAIN_LIMIT  = 400;
   localparam realtime RUN_LIMIT    = 5ms;

   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   // magnitude caps of the rounding products
   localparam logic [63:0] MAG_LIMIT     = 64'd1 << 62;
   localparam logic [63:0] PREVIEW_LIMIT = 64'd1 << 20;
   localparam logic [63:0] UNIT_INV      = 64'd65536;

   localparam longint LATENT_TOP    = 64'sd2147483647;
   localparam longint LATENT_BOTTOM = -LATENT_TOP - 1;
   localparam longint CODE_TOP      = 64'sd65535;

   localparam logic signed [LAT_W-1:0] LAT_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [LAT_W-1:0] LAT_MIN  = 32'sh8000_0000;
   localparam logic [CODE_W-1:0]       CODE_MAX = 16'hFFFF;

   // one expected result
   typedef struct {
      logic [CODE_W-1:0]       preview_code;
      logic signed [LAT_W-1:0] latent_out;
      logic                    saturated;
   } latent_update_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CODE_W-1:0]       req_cond_code = '0;
   logic [CODE_W-1:0]       req_uncond_code = '0;
   logic signed [LAT_W-1:0] req_latent_in = '0;
   logic                    rsp_valid;
   logic [CODE_W-1:0]       rsp_preview_code;
   logic signed [LAT_W-1:0] rsp_latent_out;
   logic                    rsp_saturated;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // shadow of the block's registers, updated on each accepted write
   csr_type           csr_shadow = CSR_RESET;
   latent_update_type pending_updates[$];

   int  failures        = 0;
   int  items_sent      = 0;
   int  results_seen    = 0;
   int  writes_done     = 0;
   int  settings_used   = 0;
   int  saturated_seen  = 0;
   int  preview_at_zero = 0;
   int  preview_at_top  = 0;
   bit  bursty          = 1'b0;

   guided_euler_latent_update_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cond_code    (req_cond_code),
      .req_uncond_code  (req_uncond_code),
      .req_latent_in    (req_latent_in),
      .rsp_valid        (rsp_valid),
      .rsp_preview_code (rsp_preview_code),
      .rsp_latent_out   (rsp_latent_out),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // round(a*b / 2^sh) on magnitudes, half rounds up, result capped
   function automatic logic [63:0] round_shift_mag(logic [63:0] a, logic [63:0] b,
                                                   int unsigned sh, logic [63:0] cap);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod + (128'd1 << (sh - 1));
      prod = prod >> sh;
      if (prod > {64'd0, cap})
         return cap;
      return prod[63:0];
   endfunction

   // signed version: magnitude rounded, so halves go away from zero
   function automatic longint round_shift(longint a, longint b, int unsigned sh,
                                          logic [63:0] cap);
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] mag_r;
      mag_a = (a < 0) ? 64'(-a) : 64'(a);
      mag_b = (b < 0) ? 64'(-b) : 64'(b);
      mag_r = round_shift_mag(mag_a, mag_b, sh, cap);
      return ((a < 0) != (b < 0)) ? -longint'(mag_r) : longint'(mag_r);
   endfunction

   // guided mix, noise dequantization, preview requantization and euler step
   function automatic latent_update_type predict_update(logic [CODE_W-1:0] cond,
                                                        logic [CODE_W-1:0] uncond,
                                                        logic signed [LAT_W-1:0] latent);
      longint            cond_d;
      longint            uncond_d;
      longint            mix;
      longint            noise;
      longint            sigma_noise;
      longint            x0;
      longint            quant;
      longint            step;
      longint            sum;
      longint            lat;
      logic [63:0]       inv;
      latent_update_type res;
      lat         = longint'(latent);
      cond_d      = longint'(cond) - longint'(csr_shadow.noise_offset);
      uncond_d    = longint'(uncond) - longint'(csr_shadow.noise_offset);
      mix         = uncond_d * 256
                    + longint'(csr_shadow.guidance_scale) * (cond_d - uncond_d);
      noise       = round_shift(mix, longint'(csr_shadow.noise_scale), GUIDE_FRAC,
                                MAG_LIMIT);
      sigma_noise = round_shift(noise, longint'(csr_shadow.sigma_now),
                                48 - LATENT_FRAC_BITS, MAG_LIMIT);
      x0          = lat - sigma_noise;
      // zero reciprocal scale acts as 1.0
      inv         = (csr_shadow.preview_inv_scale == '0) ? UNIT_INV
                    : 64'(csr_shadow.preview_inv_scale);
      quant       = round_shift(x0, longint'(inv), LATENT_FRAC_BITS + 16, PREVIEW_LIMIT)
                    + longint'(csr_shadow.preview_offset);
      if (quant < 0)
         quant = 0;
      if (quant > CODE_TOP)
         quant = CODE_TOP;
      step = round_shift(noise,
                         longint'(csr_shadow.sigma_after) - longint'(csr_shadow.sigma_now),
                         48 - LATENT_FRAC_BITS, MAG_LIMIT);
      sum = lat + step;
      res.saturated = 1'b0;
      if (sum > LATENT_TOP) begin
         sum = LATENT_TOP;
         res.saturated = 1'b1;
      end else if (sum < LATENT_BOTTOM) begin
         sum = LATENT_BOTTOM;
         res.saturated = 1'b1;
      end
      res.preview_code = CODE_W'(quant);
      res.latent_out   = LAT_W'(sum);
      return res;
   endfunction

   // register write as the block sees it, truncated to each width
   function automatic void apply_write(logic [CSR_INDEX_W-1:0] idx,
                                      logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_GUIDANCE_SCALE:    csr_shadow.guidance_scale    = data[GUIDE_W-1:0];
         CSR_SIGMA_NOW:         csr_shadow.sigma_now         = data[SIGMA_W-1:0];
         CSR_SIGMA_AFTER:       csr_shadow.sigma_after       = data[SIGMA_W-1:0];
         CSR_NOISE_SCALE:       csr_shadow.noise_scale       = data[SCALE_W-1:0];
         CSR_NOISE_OFFSET:      csr_shadow.noise_offset      = data[CODE_W-1:0];
         CSR_PREVIEW_INV_SCALE: csr_shadow.preview_inv_scale = data[INV_W-1:0];
         CSR_PREVIEW_OFFSET:    csr_shadow.preview_offset    = data[CODE_W-1:0];
         default: ;  // unused index, dropped
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------

   task automatic report_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%t mismatch: %s", $realtime, msg);
   endtask

   // results are sampled at the rising edge that ends their strobe cycle
   always @(posedge clock) begin : check_results
      latent_update_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_updates.size() == 0) begin
            report_failure($sformatf("result with no item outstanding: preview %0d latent %0d",
                                     rsp_preview_code, rsp_latent_out));
         end else begin
            want = pending_updates.pop_front();
            results_seen++;
            if (rsp_preview_code !== want.preview_code)
               report_failure($sformatf("preview_code expected %0d got %0d",
                                        want.preview_code, rsp_preview_code));
            if (rsp_latent_out !== want.latent_out)
               report_failure($sformatf("latent_out expected %0d got %0d",
                                        want.latent_out, rsp_latent_out));
            if (rsp_saturated !== want.saturated)
               report_failure($sformatf("saturated expected %0b got %0b",
                                        want.saturated, rsp_saturated));
            if (want.saturated)
               saturated_seen++;
            if (want.preview_code == '0)
               preview_at_zero++;
            if (want.preview_code == CODE_MAX)
               preview_at_top++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------------

   // gap after an item: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (bursty)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a falling edge; start stays high into the next item if no gap
   task automatic send_item(logic [CODE_W-1:0] cond, logic [CODE_W-1:0] uncond,
                            logic signed [LAT_W-1:0] latent);
      int gap;
      gap = pick_gap();
      start           <= 1'b1;
      req_cond_code   <= cond;
      req_uncond_code <= uncond;
      req_latent_in   <= latent;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      pending_updates.insert(pending_updates.size(), predict_update(cond, uncond, latent));
      items_sent++;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // called at a falling edge; valid is lowered for a cycle between writes
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      apply_write(idx, data);
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] guide, logic [31:0] sig_now,
                             logic [31:0] sig_after, logic [31:0] nscale,
                             logic [31:0] noffset, logic [31:0] pinv,
                             logic [31:0] poffset);
      write_reg(CSR_GUIDANCE_SCALE, guide);
      write_reg(CSR_SIGMA_NOW, sig_now);
      write_reg(CSR_SIGMA_AFTER, sig_after);
      write_reg(CSR_NOISE_SCALE, nscale);
      write_reg(CSR_NOISE_OFFSET, noffset);
      write_reg(CSR_PREVIEW_INV_SCALE, pinv);
      write_reg(CSR_PREVIEW_OFFSET, poffset);
      settings_used++;
   endtask

   // stop sending, wait for every outstanding result, then let the pipe settle
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_updates.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_updates.size() != 0) begin
         report_failure($sformatf("%0d results never arrived", pending_updates.size()));
         pending_updates.delete();
      end
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // random item content
   // ---------------------------------------------------------------------------

   // noise codes mostly close to the zero point, like real model output
   function automatic logic [CODE_W-1:0] rand_code();
      int pick;
      int near;
      pick = $urandom_range(0, 9);
      near = int'(csr_shadow.noise_offset) + int'($urandom_range(0, 1024)) - 512;
      if (near < 0)
         near = 0;
      if (near > 65535)
         near = 65535;
      if (pick < 5)
         return CODE_W'(near);
      if (pick < 8)
         return CODE_W'($urandom);
      if (pick == 8)
         return $urandom_range(0, 1) ? CODE_MAX : '0;
      return csr_shadow.noise_offset;
   endfunction

   // latents mostly within a few units, some anywhere, some at the rails
   function automatic logic signed [LAT_W-1:0] rand_latent();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         return LAT_W'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      if (pick < 8)
         return LAT_W'($urandom);
      if (pick == 8)
         return $urandom_range(0, 1) ? LAT_MAX - LAT_W'($urandom_range(0, 4096))
                                     : LAT_MIN + LAT_W'($urandom_range(0, 4096));
      return '0;
   endfunction

   task automatic pick_random_setting();
      int          style;
      logic [31:0] sig_now;
      style = $urandom_range(0, 9);
      if (style < 6) begin
         // plausible schedule: falling sigma, noise step near the usual one
         sig_now = $urandom_range(0, 14 << 16);
         set_config($urandom_range(0, 4096), sig_now, $urandom_range(0, sig_now),
                    $urandom_range(200_000, 2_000_000), $urandom_range(30_000, 35_000),
                    ($urandom_range(0, 19) == 0) ? 32'd0
                       : $urandom_range(100_000_000, 300_000_000),
                    $urandom_range(30_000, 40_000));
      end else if (style < 8) begin
         // every bit random, upper bits beyond each width are dropped
         set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (style == 8) begin
         set_config('1, '1, '1, '1, '1, '1, '1);
      end else begin
         set_config('0, '0, '0, '0, '0, '0, '0);
      end
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset settings: zero sigmas, so latents pass through unchanged
   task automatic test_reset_defaults();
      send_item(csr_shadow.noise_offset, csr_shadow.noise_offset, '0);
      send_item(CODE_MAX, '0, LAT_MAX);
      send_item('0, CODE_MAX, LAT_MIN);
      drain_pipeline();
   endtask

   // every register written, then a write to an unused index that must be ignored
   task automatic test_register_writes();
      set_config(32'd2048, 32'd655360, 32'd589824, 32'd1_000_000, 32'd32768,
                 32'd150_000_000, 32'd32768);
      write_reg(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      send_item(16'd33000, 16'd32500, '0);
      send_item(16'd32768, 16'd32768, 32'sh0002_0000);
      send_item(16'd30000, 16'd36000, -32'sh0001_0000);
      drain_pipeline();
   endtask

   // code and latent rails in every combination that matters
   task automatic test_field_extremes();
      send_item('0, '0, LAT_MAX);
      send_item('0, '0, LAT_MIN);
      send_item(CODE_MAX, CODE_MAX, '0);
      send_item(CODE_MAX, CODE_MAX, -32'sd1);
      send_item('0, CODE_MAX, LAT_MAX);
      send_item(CODE_MAX, '0, LAT_MIN);
      send_item('0, CODE_MAX, '0);
      send_item(CODE_MAX, '0, -32'sd1);
      drain_pipeline();
   endtask

   // zero reciprocal scale is taken as 1.0; codes at the zero point give no noise
   task automatic test_zero_inv_scale();
      write_reg(CSR_PREVIEW_INV_SCALE, '0);
      send_item(csr_shadow.noise_offset, csr_shadow.noise_offset, 32'sh0001_0000);
      send_item(csr_shadow.noise_offset, csr_shadow.noise_offset, -32'sh0003_0000);
      // 1.5 rounds away from zero
      send_item(csr_shadow.noise_offset, csr_shadow.noise_offset, 32'sh0001_8000);
      drain_pipeline();
   endtask

   // huge preview clamps to both code rails, updated latent saturates both ways
   task automatic test_clamp_and_saturation();
      set_config(32'hFFFF, 32'hFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                 32'hFFFF);
      send_item(CODE_MAX, '0, LAT_MAX);
      send_item('0, CODE_MAX, LAT_MIN);
      send_item('0, '0, '0);
      drain_pipeline();
      set_config(32'd0, 32'd0, 32'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'd1, 32'd0);
      send_item('0, '0, LAT_MIN);
      send_item(CODE_MAX, CODE_MAX, LAT_MAX);
      send_item(16'd12345, '0, 32'sh4000_0000);
      drain_pipeline();
   endtask

   // phases of random items, each under its own register setting
   task automatic test_random_phases();
      int sent;
      int phase_len;
      bit paused_once;
      sent        = 0;
      paused_once = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         pick_random_setting();
         bursty    = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 160);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            // hold the sender off mid-phase until the pipeline is empty
            if (i == phase_len / 2 && (!paused_once || $urandom_range(0, 2) == 0)) begin
               drain_pipeline();
               paused_once = 1'b1;
            end
            send_item(rand_code(), rand_code(), rand_latent());
            sent++;
         end
         bursty = 1'b0;
         drain_pipeline();
      end
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_register_writes();
      test_field_extremes();
      test_zero_inv_scale();
      test_clamp_and_saturation();
      test_random_phases();

      $display("covered %0d items and %0d results under %0d register settings (%0d writes)",
               items_sent, results_seen, settings_used, writes_done);
      $display("results: %0d saturated latents, %0d previews clamped low, %0d high",
               saturated_seen, preview_at_zero, preview_at_top);
      if (failures == 0) begin
         $display("guided_euler_latent_update_unit_tb: PASS");
      end else begin
         $display("%0d mismatches in total", failures);
         $display("guided_euler_latent_update_unit_tb: FAIL");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #(RUN_LIMIT);
      $display("timeout with %0d results outstanding", pending_updates.size());
      $display("guided_euler_latent_update_unit_tb: FAIL");
      $finish;
   end

endmodule
